// ===== design/keyboard_serial_port_with_rx_fifo_assert.svh =====
// ----------------------------------------------------------------------------
// keyboard serial port assertion macros
// implication checks used by the port checker
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_SERIAL_PORT_WITH_RX_FIFO_ASSERT_SVH
`define KEYBOARD_SERIAL_PORT_WITH_RX_FIFO_ASSERT_SVH

// same-cycle implication
`define KSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyboard serial port check failed");

// next-cycle implication
`define KSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyboard serial port check failed");

`endif

// ===== design/ksp_pkg.sv =====
// ----------------------------------------------------------------------------
// ksp_pkg
// shared codes, command bytes and status structs of the keyboard serial port
// ----------------------------------------------------------------------------
package ksp_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_READ   = 2'd1,
        OP_WRITE  = 2'd2,
        OP_STATUS = 2'd3
    } t_op;

    // host command bytes with special handling
    localparam logic [7:0] CMD_IGNORE_A = 8'hC0;
    localparam logic [7:0] CMD_IGNORE_B = 8'hC1;
    localparam logic [7:0] CMD_ENABLE   = 8'hE0;

    // status write clear bits
    localparam int STAT_CLR_PARITY  = 2;
    localparam int STAT_CLR_OVERRUN = 3;

    typedef struct packed {
        logic       rx_push;
        logic [7:0] rx_data;
        logic       zero_push;
        logic       pop;
    } t_fifo_req;

    typedef struct packed {
        logic nonempty;
        logic overrun;
    } t_fifo_stat;

    typedef struct packed {
        logic busy;
        logic line;
        logic enable_cmd;
    } t_tx_stat;

endpackage

// ===== design/ksp_rx.sv =====
// ----------------------------------------------------------------------------
// ksp_rx
// receive deserializer: start bit, 8 data bits lsb first, 2 skipped bits
// ----------------------------------------------------------------------------
module ksp_rx (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_sample,
    input  logic       i_bit,
    output logic       o_push,
    output logic [7:0] o_data
);

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_DATA,
        RX_SKIP
    } t_rx_state;

    t_rx_state   r_state, n_state;
    logic [7:0]  r_byte, n_byte;
    logic [3:0]  r_seen, n_seen;
    logic [1:0]  r_skip, n_skip;

    always_comb begin
        n_state = r_state;
        n_byte  = r_byte;
        n_seen  = r_seen;
        n_skip  = r_skip;
        o_push  = 1'b0;
        o_data  = r_byte | (8'(i_bit) << r_seen[2:0]);
        if (i_sample) begin
            unique case (r_state)
                RX_IDLE: begin
                    if (!i_bit) begin
                        n_state = RX_DATA;
                        n_byte  = 8'd0;
                        n_seen  = 4'd0;
                        n_skip  = 2'd0;
                    end
                end
                RX_DATA: begin
                    n_byte = o_data;
                    n_seen = r_seen + 4'd1;
                    if (n_seen >= 4'd8) begin
                        o_push  = 1'b1;
                        n_state = RX_SKIP;
                        n_skip  = 2'd2;
                    end
                end
                RX_SKIP: begin
                    if (r_skip != 2'd0) begin
                        n_skip = r_skip - 2'd1;
                        if (n_skip == 2'd0) begin
                            n_state = RX_IDLE;
                        end
                    end
                end
                default: begin
                    n_state = RX_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RX_IDLE;
            r_seen  <= 4'd0;
            r_skip  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_seen  <= n_seen;
            r_skip  <= n_skip;
        end
        r_byte <= n_byte;
    end

endmodule

// ===== design/ksp_tx.sv =====
// ----------------------------------------------------------------------------
// ksp_tx
// transmit serializer for odd-parity 8o1 frames toward the keyboard
// ----------------------------------------------------------------------------
module ksp_tx (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic              i_write,
    input  logic [7:0]        i_wdata,
    output ksp_pkg::t_tx_stat o_stat
);

    typedef enum logic [2:0] {
        TX_IDLE,
        TX_START,
        TX_DATA,
        TX_PARITY,
        TX_STOP
    } t_tx_state;

    t_tx_state   r_state, n_state;
    logic [7:0]  r_byte, n_byte;
    logic [3:0]  r_left, n_left;
    logic        r_parity, n_parity;
    logic        r_line, n_line;
    logic        busy;
    logic        load;

    assign busy = (r_state != TX_IDLE);
    assign load = i_write && !busy && (i_wdata != ksp_pkg::CMD_IGNORE_A)
                  && (i_wdata != ksp_pkg::CMD_IGNORE_B);

    always_comb begin
        n_state  = r_state;
        n_byte   = r_byte;
        n_left   = r_left;
        n_parity = r_parity;
        n_line   = r_line;
        if (load) begin
            n_state  = TX_START;
            n_byte   = i_wdata;
            n_left   = 4'd8;
            n_parity = 1'b1;
            n_line   = 1'b0;
        end else if (i_shift && busy) begin
            unique case (r_state)
                TX_START: begin
                    n_state = TX_DATA;
                end
                TX_DATA: begin
                    n_byte   = {1'b0, r_byte[7:1]};
                    n_parity = r_parity ^ r_byte[0];
                    n_line   = r_byte[0];
                    n_left   = r_left - 4'd1;
                    if (n_left == 4'd0) begin
                        n_state = TX_PARITY;
                    end
                end
                TX_PARITY: begin
                    n_line  = r_parity;
                    n_state = TX_STOP;
                end
                TX_STOP: begin
                    n_line  = 1'b1;
                    n_state = TX_IDLE;
                    n_left  = 4'd0;
                end
                default: begin
                    n_line  = 1'b1;
                    n_state = TX_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy       = (n_state != TX_IDLE);
    assign o_stat.line       = n_line;
    assign o_stat.enable_cmd = load && (i_wdata == ksp_pkg::CMD_ENABLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= TX_IDLE;
            r_left   <= 4'd0;
            r_parity <= 1'b0;
            r_line   <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_left   <= n_left;
            r_parity <= n_parity;
            r_line   <= n_line;
        end
        r_byte <= n_byte;
    end

endmodule

// ===== design/ksp_fifo.sv =====
// ----------------------------------------------------------------------------
// ksp_fifo
// receive byte queue with registered read port and zero-byte marks
// ----------------------------------------------------------------------------
module ksp_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ksp_pkg::t_fifo_req  i_req,
    output ksp_pkg::t_fifo_stat o_stat,
    output logic [7:0]          o_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_zf, n_zf;
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [FW-1:0]    r_fill, n_fill;
    logic [FW-1:0]    room;
    logic [1:0]       zcnt;
    logic             full;
    logic             rx_ok;
    logic             do_pop;
    logic [AW-1:0]    za0, za1, za2;
    logic [7:0]       r_q;
    logic             r_qz;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] ptr,
                                               input logic [1:0] k);
        logic [AW:0] s;
        s = {1'b0, ptr} + (AW+1)'(k);
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    always_comb begin
        full   = (r_fill == FW'(DEPTH));
        room   = FW'(DEPTH) - r_fill;
        zcnt   = 2'd0;
        if (i_req.zero_push) begin
            zcnt = (room >= FW'(3)) ? 2'd3 : room[1:0];
        end
        rx_ok  = i_req.rx_push && !full;
        do_pop = i_req.pop && (r_fill != '0);
        n_fill = r_fill + FW'(zcnt) + FW'(rx_ok) - FW'(do_pop);
        o_stat.nonempty = (n_fill != '0);
        o_stat.overrun  = (i_req.rx_push && full) || (i_req.zero_push && (room < FW'(3)));

        za0 = r_wptr;
        za1 = wrap_add(r_wptr, 2'd1);
        za2 = wrap_add(r_wptr, 2'd2);
        if (rx_ok) begin
            n_wptr = za1;
        end else if (zcnt != 2'd0) begin
            n_wptr = wrap_add(r_wptr, zcnt);
        end else begin
            n_wptr = r_wptr;
        end
        n_rptr = do_pop ? wrap_add(r_rptr, 2'd1) : r_rptr;

        // zero bytes are only marked, the data slot is left alone
        for (int i = 0; i < DEPTH; i++) begin
            if ((zcnt > 2'd0 && za0 == AW'(i)) || (zcnt > 2'd1 && za1 == AW'(i))
                || (zcnt > 2'd2 && za2 == AW'(i))) begin
                n_zf[i] = 1'b1;
            end else if (rx_ok && r_wptr == AW'(i)) begin
                n_zf[i] = 1'b0;
            end else begin
                n_zf[i] = r_zf[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_ok) begin
            r_mem[r_wptr] <= i_req.rx_data;
        end
        if (i_req.pop) begin
            r_q  <= r_mem[r_rptr];
            // a read of an empty queue returns zero
            r_qz <= !do_pop || r_zf[r_rptr];
        end
        r_zf <= n_zf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    assign o_rdata = r_qz ? 8'd0 : r_q;

endmodule

// ===== design/keyboard_serial_port_with_rx_fifo.sv =====
// ----------------------------------------------------------------------------
// keyboard_serial_port_with_rx_fifo
// keyboard serial port: bit ticks, host data and status access, receive queue
// ----------------------------------------------------------------------------
// each accepted input beat yields one result beat, held in the stage-one register and then
//   the output register; throughput: one beat per cycle while the output is not stalled;
//   an output stall holds the stage-one register and then stalls the input
// reset: synchronous active low; the fifo store is not cleared, only its
//   pointers and fill count
module keyboard_serial_port_with_rx_fifo #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [7:0] wdata, [8] line_level, [15:9] zero
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata   // [7:0] rdata, [11:8] status, [12] irq,
                                         // [13] kbd_clock, [14] tx_line, [15] zero
);

    ksp_pkg::t_op        op;
    logic                accept;
    logic                fall;
    logic                s1_move;
    logic                rx_push;
    logic [7:0]          rx_data;
    ksp_pkg::t_fifo_req  fifo_req;
    ksp_pkg::t_fifo_stat fifo_stat;
    ksp_pkg::t_tx_stat   tx_stat;
    logic [7:0]          fifo_rdata;

    logic r_kbd_clk, n_kbd_clk;
    logic r_irq_en, n_irq_en;
    logic r_irq, n_irq;
    logic r_par_err, n_par_err;
    logic r_ovr_err, n_ovr_err;

    logic       r_s1_valid;
    logic       r_s1_pop;
    logic [3:0] r_s1_status;
    logic       r_s1_irq;
    logic       r_s1_clk;
    logic       r_s1_line;
    logic       r_out_valid;
    logic [15:0] r_out_data;

    assign op      = ksp_pkg::t_op'(i_s_axis_tuser);
    assign s1_move = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_move;
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign fall    = accept && (op == ksp_pkg::OP_TICK) && r_kbd_clk;

    ksp_rx u_rx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (fall),
        .i_bit    (i_s_axis_tdata[8]),
        .o_push   (rx_push),
        .o_data   (rx_data)
    );

    ksp_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (fall),
        .i_write (accept && (op == ksp_pkg::OP_WRITE)),
        .i_wdata (i_s_axis_tdata[7:0]),
        .o_stat  (tx_stat)
    );

    always_comb begin
        fifo_req.rx_push   = rx_push;
        fifo_req.rx_data   = rx_data;
        fifo_req.zero_push = tx_stat.enable_cmd;
        fifo_req.pop       = accept && (op == ksp_pkg::OP_READ);
    end

    ksp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fifo_req),
        .o_stat  (fifo_stat),
        .o_rdata (fifo_rdata)
    );

    always_comb begin
        n_kbd_clk = r_kbd_clk;
        n_irq_en  = r_irq_en || tx_stat.enable_cmd;
        n_par_err = r_par_err;
        n_ovr_err = r_ovr_err || fifo_stat.overrun;
        if (accept) begin
            unique case (op)
                ksp_pkg::OP_TICK: begin
                    n_kbd_clk = !r_kbd_clk;
                end
                ksp_pkg::OP_STATUS: begin
                    // one bit per sticky flag, a 1 clears it
                    if (i_s_axis_tdata[ksp_pkg::STAT_CLR_PARITY]) begin
                        n_par_err = 1'b0;
                    end
                    if (i_s_axis_tdata[ksp_pkg::STAT_CLR_OVERRUN]) begin
                        n_ovr_err = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
        n_irq = (accept && n_irq_en) ? fifo_stat.nonempty : r_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kbd_clk   <= 1'b1;
            r_irq_en    <= 1'b0;
            r_irq       <= 1'b0;
            r_par_err   <= 1'b0;
            r_ovr_err   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_kbd_clk   <= n_kbd_clk;
            r_irq_en    <= n_irq_en;
            r_irq       <= n_irq;
            r_par_err   <= n_par_err;
            r_ovr_err   <= n_ovr_err;
            r_s1_valid  <= accept || (r_s1_valid && !s1_move);
            r_out_valid <= s1_move || (r_out_valid && !i_m_axis_tready);
        end
        if (accept) begin
            r_s1_pop    <= (op == ksp_pkg::OP_READ);
            r_s1_status <= {n_ovr_err, n_par_err, fifo_stat.nonempty, !tx_stat.busy};
            r_s1_irq    <= n_irq;
            r_s1_clk    <= n_kbd_clk;
            r_s1_line   <= tx_stat.line;
        end
        if (s1_move) begin
            // fifo read data lines up with the stage that issued the pop
            r_out_data <= {1'b0, r_s1_line, r_s1_clk, r_s1_irq, r_s1_status,
                           r_s1_pop ? fifo_rdata : 8'd0};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== design/ksp_checker.sv =====
// ----------------------------------------------------------------------------
// ksp_checker
// port-level checks on the keyboard serial port, bound to the top level
// ----------------------------------------------------------------------------
`include "keyboard_serial_port_with_rx_fifo_assert.svh"

module ksp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);

    // a stalled result beat holds
    `KSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // input side only stalls behind a full result path
    `KSP_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !o_s_axis_tready,
        o_m_axis_tvalid && !i_m_axis_tready)

    // interrupt only with bytes waiting
    `KSP_ASSERT_IMP(a_irq_rx, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[12],
        o_m_axis_tdata[9])

    // idle transmitter leaves the line at mark, with no parity error flagged
    `KSP_ASSERT_IMP(a_tx_mark, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[8],
        o_m_axis_tdata[14] && !o_m_axis_tdata[10])

endmodule

bind keyboard_serial_port_with_rx_fifo ksp_checker u_ksp_checker (.*);

// ===== tb/tb_keyboard_serial_port_with_rx_fifo.sv =====
// ----------------------------------------------------------------------------
// tb_keyboard_serial_port_with_rx_fifo
// streams host beats (bit ticks, data reads, data writes, status writes) into
// the port with random gaps and output stalls; a cycle-free model of the port
// predicts every result beat, which the monitor compares field by field
// ----------------------------------------------------------------------------
module tb_keyboard_serial_port_with_rx_fifo;

    localparam int FIFO_DEPTH    = 16;
    localparam int RANDOM_BEATS  = 1650;
    localparam int SETTLE_CYCLES = 20;

    typedef enum logic [1:0] {RXS_IDLE, RXS_DATA, RXS_SKIP} t_rx_phase;
    typedef enum logic [2:0] {TXS_IDLE, TXS_START, TXS_DATA, TXS_PARITY, TXS_STOP} t_tx_phase;

    typedef struct packed {
        ksp_pkg::t_op op;
        logic [7:0]   wdata;
        logic         line;
        logic         drain;  // hold this beat until every result is back
    } t_host_beat;

    typedef struct packed {
        logic [7:0] rdata;
        logic [3:0] status;
        logic       irq;
        logic       kbd_clock;
        logic       tx_line;
    } t_port_view;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = ksp_pkg::OP_TICK;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;

    keyboard_serial_port_with_rx_fifo #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [7:0] wdata, [8] line_level, [15:9] zero
        .i_s_axis_tuser  (s_tuser),   // [1:0] op
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)    // [7:0] rdata, [11:8] status, [12] irq,
                                      // [13] kbd_clock, [14] tx_line, [15] zero
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    t_host_beat host_beats_to_send[$];
    t_port_view expected_views[$];
    t_host_beat beat_on_bus;

    int  n_queued = 0;
    int  n_accepted = 0;
    int  n_checked = 0;
    int  n_errors = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  send_steady = 0;
    bit  recv_steady = 0;
    bit  hold_next = 0;
    bit  gen_clk_level = 1;

    // port model state
    logic       clk_level = 1'b1;
    t_rx_phase  rx_state = RXS_IDLE;
    logic [7:0] rx_shift = '0;
    logic [3:0] rx_bits_got = '0;
    logic [1:0] rx_skip_left = '0;
    logic [7:0] rx_bytes_held[$];
    logic       sticky_parity = 1'b0;
    logic       sticky_overrun = 1'b0;
    logic       irq_level = 1'b0;
    logic       irq_armed = 1'b0;
    t_tx_phase  tx_phase = TXS_IDLE;
    logic [7:0] tx_shift = '0;
    logic [3:0] tx_left = '0;
    logic       tx_parity = 1'b0;
    logic       tx_busy = 1'b0;
    logic       tx_line_level = 1'b1;

    int n_rx_bytes = 0;
    int n_overrun_drops = 0;
    int n_pops = 0;
    int n_tx_frames = 0;

    function automatic void store_rx_byte(logic [7:0] b);
        if (rx_bytes_held.size() >= FIFO_DEPTH) begin
            sticky_overrun = 1'b1;
            n_overrun_drops++;
        end else begin
            rx_bytes_held.push_back(b);
        end
    endfunction

    function automatic void sample_rx_line(logic line);
        case (rx_state)
            RXS_IDLE: begin
                if (!line) begin
                    rx_state = RXS_DATA;
                    rx_shift = '0;
                    rx_bits_got = '0;
                end
            end
            RXS_DATA: begin
                rx_shift[rx_bits_got[2:0]] = line;
                rx_bits_got = rx_bits_got + 4'd1;
                if (rx_bits_got == 4'd8) begin
                    store_rx_byte(rx_shift);
                    n_rx_bytes++;
                    rx_state = RXS_SKIP;
                    rx_skip_left = 2'd2;
                end
            end
            default: begin
                rx_skip_left = rx_skip_left - 2'd1;
                if (rx_skip_left == 2'd0) rx_state = RXS_IDLE;
            end
        endcase
    endfunction

    function automatic void shift_tx_bit();
        if (tx_busy) begin
            case (tx_phase)
                TXS_START: tx_phase = TXS_DATA;
                TXS_DATA: begin
                    tx_line_level = tx_shift[0];
                    tx_parity = tx_parity ^ tx_shift[0];
                    tx_shift = tx_shift >> 1;
                    tx_left = tx_left - 4'd1;
                    if (tx_left == 4'd0) tx_phase = TXS_PARITY;
                end
                TXS_PARITY: begin
                    tx_line_level = tx_parity;
                    tx_phase = TXS_STOP;
                end
                default: begin
                    tx_line_level = 1'b1;
                    tx_phase = TXS_IDLE;
                    tx_busy = 1'b0;
                    tx_left = '0;
                    n_tx_frames++;
                end
            endcase
        end
    endfunction

    function automatic t_port_view next_port_view(t_host_beat b);
        t_port_view v;
        v = '0;
        case (b.op)
            ksp_pkg::OP_TICK: begin
                clk_level = ~clk_level;
                if (!clk_level) begin
                    sample_rx_line(b.line);
                    shift_tx_bit();
                end
            end
            ksp_pkg::OP_READ: begin
                if (rx_bytes_held.size() != 0) begin
                    v.rdata = rx_bytes_held.pop_front();
                    n_pops++;
                end
            end
            ksp_pkg::OP_WRITE: begin
                if (!tx_busy && b.wdata != ksp_pkg::CMD_IGNORE_A
                    && b.wdata != ksp_pkg::CMD_IGNORE_B) begin
                    if (b.wdata == ksp_pkg::CMD_ENABLE) begin
                        irq_armed = 1'b1;
                        repeat (3) store_rx_byte(8'h00);
                    end
                    tx_phase = TXS_START;
                    tx_shift = b.wdata;
                    tx_left = 4'd8;
                    tx_parity = 1'b1;
                    tx_busy = 1'b1;
                    tx_line_level = 1'b0;
                end
            end
            ksp_pkg::OP_STATUS: begin
                if (b.wdata[ksp_pkg::STAT_CLR_PARITY]) sticky_parity = 1'b0;
                if (b.wdata[ksp_pkg::STAT_CLR_OVERRUN]) sticky_overrun = 1'b0;
            end
        endcase
        if (irq_armed) irq_level = (rx_bytes_held.size() != 0);
        v.status = {sticky_overrun, sticky_parity, rx_bytes_held.size() != 0, !tx_busy};
        v.irq = irq_level;
        v.kbd_clock = clk_level;
        v.tx_line = tx_line_level;
        return v;
    endfunction

    // ---------------- stimulus generation ----------------

    function automatic void queue_beat(ksp_pkg::t_op op, logic [7:0] wdata, logic line);
        t_host_beat b;
        b.op = op;
        b.wdata = wdata;
        b.line = line;
        b.drain = hold_next;
        hold_next = 0;
        if (op == ksp_pkg::OP_TICK) gen_clk_level = ~gen_clk_level;
        host_beats_to_send.push_back(b);
        n_queued++;
    endfunction

    function automatic logic [7:0] pick_write_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return ksp_pkg::CMD_ENABLE;
        if (r < 15) return ksp_pkg::CMD_IGNORE_A;
        if (r < 20) return ksp_pkg::CMD_IGNORE_B;
        if (r < 25) return 8'h00;
        if (r < 30) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void queue_side_op();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) queue_beat(ksp_pkg::OP_READ, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
        else if (r < 8) queue_beat(ksp_pkg::OP_WRITE, pick_write_byte(),
                                   1'($urandom_range(0, 1)));
        else queue_beat(ksp_pkg::OP_STATUS, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
    endfunction

    // ticks until one lands on a falling edge carrying the wanted level
    function automatic void send_line_bit(logic value, int side_pct);
        bit falling;
        bit done;
        done = 0;
        while (!done) begin
            if ($urandom_range(0, 99) < side_pct) queue_side_op();
            falling = gen_clk_level;
            queue_beat(ksp_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                       falling ? value : 1'($urandom_range(0, 1)));
            done = falling;
        end
    endfunction

    function automatic void queue_frame(logic [7:0] data, int side_pct);
        send_line_bit(1'b1, side_pct);
        send_line_bit(1'b0, side_pct);
        for (int i = 0; i < 8; i++) send_line_bit(data[i], side_pct);
        repeat (2) send_line_bit(1'($urandom_range(0, 1)), side_pct);
    endfunction

    function automatic logic [7:0] pick_frame_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 149) == 0) send_steady = !send_steady;
        if (send_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic int pick_stall();
        int r;
        if ($urandom_range(0, 199) == 0) recv_steady = !recv_steady;
        if (recv_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 75) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_views.push_back(next_port_view(beat_on_bus));
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (host_beats_to_send.size() == 0 ||
                             (host_beats_to_send[0].drain && expected_views.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    beat_on_bus = host_beats_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'd0, beat_on_bus.line, beat_on_bus.wdata};
                    s_tuser <= beat_on_bus.op;
                    gap_left = pick_gap();
                end
            end
        end
    end

    // ---------------- receiver and monitor ----------------

    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_stall();
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge clk) begin
        t_port_view want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_views.size() == 0) begin
                $display("%0t: result beat with nothing expected: expected none, actual %h",
                         $time, m_tdata);
                n_errors++;
            end else begin
                want = expected_views.pop_front();
                n_checked++;
                check_field("rdata", want.rdata, m_tdata[7:0]);
                check_field("status", 8'(want.status), 8'(m_tdata[11:8]));
                check_field("irq", 8'(want.irq), 8'(m_tdata[12]));
                check_field("kbd_clock", 8'(want.kbd_clock), 8'(m_tdata[13]));
                check_field("tx_line", 8'(want.tx_line), 8'(m_tdata[14]));
            end
        end
    end

    // ---------------- sequence and end of run ----------------

    initial begin
        int pick;
        int directed_beats;

        // register corner cases
        queue_beat(ksp_pkg::OP_READ, 8'h00, 1'b0);          // empty queue reads zero
        queue_beat(ksp_pkg::OP_STATUS, 8'hFF, 1'b1);
        queue_beat(ksp_pkg::OP_STATUS, 8'h00, 1'b0);
        queue_beat(ksp_pkg::OP_WRITE, ksp_pkg::CMD_IGNORE_A, 1'b0);
        queue_beat(ksp_pkg::OP_WRITE, ksp_pkg::CMD_IGNORE_B, 1'b1);
        queue_beat(ksp_pkg::OP_WRITE, 8'h00, 1'b0);
        queue_beat(ksp_pkg::OP_WRITE, ksp_pkg::CMD_ENABLE, 1'b0);    // busy: dropped
        queue_beat(ksp_pkg::OP_WRITE, 8'hFF, 1'b1);
        queue_beat(ksp_pkg::OP_READ, 8'hFF, 1'b1);
        // a received byte while the interrupt is still disarmed
        queue_frame(8'hA5, 0);
        hold_next = 1;
        queue_beat(ksp_pkg::OP_WRITE, ksp_pkg::CMD_ENABLE, 1'b0);
        repeat (5) queue_beat(ksp_pkg::OP_READ, 8'h00, 1'b0);
        queue_beat(ksp_pkg::OP_STATUS, 8'h0C, 1'b1);
        directed_beats = n_queued;

        while (n_queued < directed_beats + RANDOM_BEATS) begin
            if ($urandom_range(0, 99) < 2) hold_next = 1;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                queue_frame(pick_frame_byte(), 15);
            end else if (pick < 55) begin
                queue_beat(ksp_pkg::OP_WRITE, pick_write_byte(), 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 24))
                    queue_beat(ksp_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)));
            end else if (pick < 70) begin
                repeat ($urandom_range(1, 6))
                    queue_beat(ksp_pkg::OP_READ, 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)));
            end else if (pick < 77) begin
                queue_beat(ksp_pkg::OP_STATUS, 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
            end else if (pick < 80) begin
                // no reads: fills the queue past its depth
                repeat (5) begin
                    queue_beat(ksp_pkg::OP_WRITE, ksp_pkg::CMD_ENABLE,
                               1'($urandom_range(0, 1)));
                    queue_frame(pick_frame_byte(), 0);
                end
            end else begin
                repeat ($urandom_range(1, 8))
                    queue_beat(ksp_pkg::t_op'($urandom_range(0, 3)),
                               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (host_beats_to_send.size() != 0 || s_tvalid || expected_views.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d host beats and compared %0d results, %0d mismatching fields",
                 n_accepted, n_checked, n_errors);
        $display("framed in %0d bytes (%0d dropped on overrun), popped %0d, sent %0d frames",
                 n_rx_bytes, n_overrun_drops, n_pops, n_tx_frames);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout with %0d beats unsent and %0d results outstanding",
                 host_beats_to_send.size(), expected_views.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
